### sv/rae_pkg.sv
// Package for the radix-64 armor encoder: shared types, constants and the
// base64 alphabet function. Depends on nothing; every other file imports it.
package rae_pkg;

   // Configuration register map.
   localparam int CsrIndexWidth = 2;
   localparam logic [CsrIndexWidth-1:0] CSR_CRC_INITIAL    = 2'd0;
   localparam logic [CsrIndexWidth-1:0] CSR_CRC_POLYNOMIAL = 2'd1;

   // CRC-24 defaults (OpenPGP values).
   localparam int CrcWidth = 24;
   localparam logic [CrcWidth-1:0] CrcInitialReset    = 24'hB704CE;
   localparam logic [CrcWidth-1:0] CrcPolynomialReset = 24'h864CFB;

   // Depth of the queue between front and back.
   localparam int FifoDepth = 4;

   // Padding character '='.
   localparam logic [6:0] PadChar = 7'h3D;

   // One unit of work for the back end: an optional text group and an
   // optional checksum group.
   typedef struct packed {
      logic [23:0]         grp;        // text group, first byte in the high bits
      logic [1:0]          grp_bytes;  // real bytes in grp (0 means no group)
      logic                has_crc;    // checksum group follows
      logic [CrcWidth-1:0] crc;        // checksum value
   } rae_job_type;

   // Maps a 6-bit value to its character of the standard base64 alphabet.
   function automatic logic [6:0] b64_char(input logic [5:0] v);
      logic [6:0] ch;
      if (v < 6'd26) begin
         ch = 7'h41 + {1'b0, v};
      end else if (v < 6'd52) begin
         ch = 7'h61 + ({1'b0, v} - 7'd26);
      end else if (v < 6'd62) begin
         ch = 7'h30 + ({1'b0, v} - 7'd52);
      end else if (v == 6'd62) begin
         ch = 7'h2B;
      end else begin
         ch = 7'h2F;
      end
      return ch;
   endfunction

endpackage

### sv/rae_front.sv
// Front end of the armor encoder: accepts message bytes, folds the CRC-24,
// groups bytes and pushes work into the queue. Depends on rae_pkg.
module rae_front (
   input  logic                           clock,
   input  logic                           reset,
   // Input transaction
   input  logic                           in_valid,
   output logic                           in_ready,
   input  logic [7:0]                     data_byte,
   input  logic                           byte_present,
   input  logic                           end_of_message,
   // Configuration write
   input  logic                           csr_valid,
   input  logic [rae_pkg::CsrIndexWidth-1:0] csr_index,
   input  logic [rae_pkg::CrcWidth-1:0]   csr_data,
   // Queue side
   input  logic                           queue_full,
   output logic                           push,
   output rae_pkg::rae_job_type           push_job
);
   import rae_pkg::*;

   logic [CrcWidth-1:0] crc_initial_ff, crc_initial_in;
   logic [CrcWidth-1:0] crc_poly_ff, crc_poly_in;
   logic [CrcWidth-1:0] crc_ff, crc_in;
   logic [15:0]         held_ff, held_in;
   logic [1:0]          count_ff, count_in;
   logic                accept;
   logic [CrcWidth-1:0] crc_folded;
   logic [CrcWidth-1:0] crc_msg;

   // Folds one byte into the CRC, MSB first, one bit per step.
   function automatic logic [CrcWidth-1:0] fold(input logic [CrcWidth-1:0] crc,
                                                input logic [7:0] b,
                                                input logic [CrcWidth-1:0] poly);
      logic [CrcWidth-1:0] c;
      logic                top;
      c = crc ^ {b, 16'h0000};
      for (int i = 0; i < 8; i++) begin
         top = c[CrcWidth-1];
         c   = {c[CrcWidth-2:0], 1'b0};
         if (top) begin
            c = c ^ poly;
         end
      end
      return c;
   endfunction

   assign in_ready   = !queue_full;
   assign accept     = in_valid && in_ready;
   assign crc_folded = fold(crc_ff, data_byte, crc_poly_ff);
   assign crc_msg    = byte_present ? crc_folded : crc_ff;

   // Configuration registers; writes to unknown indexes are dropped.
   always_comb begin
      crc_initial_in = crc_initial_ff;
      crc_poly_in    = crc_poly_ff;
      if (csr_valid) begin
         if (csr_index == CSR_CRC_INITIAL) begin
            crc_initial_in = csr_data;
         end else if (csr_index == CSR_CRC_POLYNOMIAL) begin
            crc_poly_in = csr_data;
         end
      end
   end

   // Byte grouping, CRC update and job assembly.
   always_comb begin
      crc_in   = crc_ff;
      held_in  = held_ff;
      count_in = count_ff;
      push     = 1'b0;
      push_job = '0;
      if (accept) begin
         if (byte_present) begin
            crc_in = crc_folded;
            if (count_ff == 2'd2) begin
               push_job.grp       = {held_ff, data_byte};
               push_job.grp_bytes = 2'd3;
               count_in           = 2'd0;
            end else begin
               held_in  = {held_ff[7:0], data_byte};
               count_in = count_ff + 2'd1;
            end
         end
         if (end_of_message) begin
            // Pad out a partial group, then the checksum group.
            if (count_in == 2'd1) begin
               push_job.grp       = {held_in[7:0], 16'h0000};
               push_job.grp_bytes = 2'd1;
            end else if (count_in == 2'd2) begin
               push_job.grp       = {held_in, 8'h00};
               push_job.grp_bytes = 2'd2;
            end
            push_job.has_crc = 1'b1;
            push_job.crc     = crc_msg;
            crc_in           = crc_initial_ff;
            count_in         = 2'd0;
            held_in          = '0;
         end
         push = push_job.has_crc || (push_job.grp_bytes != 2'd0);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         crc_initial_ff <= CrcInitialReset;
         crc_poly_ff    <= CrcPolynomialReset;
         crc_ff         <= CrcInitialReset;
         held_ff        <= '0;
         count_ff       <= '0;
      end else begin
         crc_initial_ff <= crc_initial_in;
         crc_poly_ff    <= crc_poly_in;
         crc_ff         <= crc_in;
         held_ff        <= held_in;
         count_ff       <= count_in;
      end
   end

endmodule

### sv/rae_fifo.sv
// Short queue of jobs between the front and back ends of the armor encoder.
// Depends on rae_pkg for the job type.
module rae_fifo #(
   parameter int Depth = rae_pkg::FifoDepth
) (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 push,
   input  rae_pkg::rae_job_type push_job,
   output logic                 full,
   input  logic                 pop,
   output logic                 empty,
   output rae_pkg::rae_job_type head_job
);
   import rae_pkg::*;

   localparam int PtrWidth = (Depth > 1) ? $clog2(Depth) : 1;
   localparam int CntWidth = $clog2(Depth + 1);

   rae_job_type         mem_ff [Depth];
   logic [PtrWidth-1:0] wr_ptr_ff, wr_ptr_in;
   logic [PtrWidth-1:0] rd_ptr_ff, rd_ptr_in;
   logic [CntWidth-1:0] count_ff, count_in;
   logic                do_push, do_pop;

   assign full     = (count_ff == CntWidth'(Depth));
   assign empty    = (count_ff == '0);
   assign do_push  = push && !full;
   assign do_pop   = pop && !empty;
   assign head_job = mem_ff[rd_ptr_ff];

   // Pointer and occupancy update with wrap at the last entry.
   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      count_in  = count_ff;
      if (do_push) begin
         wr_ptr_in = (wr_ptr_ff == PtrWidth'(Depth - 1)) ? '0 : wr_ptr_ff + 1'b1;
      end
      if (do_pop) begin
         rd_ptr_in = (rd_ptr_ff == PtrWidth'(Depth - 1)) ? '0 : rd_ptr_ff + 1'b1;
      end
      if (do_push && !do_pop) begin
         count_in = count_ff + 1'b1;
      end else if (do_pop && !do_push) begin
         count_in = count_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   // Storage needs no reset.
   always_ff @(posedge clock) begin
      if (do_push) begin
         mem_ff[wr_ptr_ff] <= push_job;
      end
   end

endmodule

### sv/rae_back.sv
// Back end of the armor encoder: expands queued jobs into base64 characters,
// one per cycle while not stalled, into a registered output. Depends on rae_pkg.
module rae_back (
   input  logic                 clock,
   input  logic                 reset,
   // Queue side
   input  logic                 queue_empty,
   input  rae_pkg::rae_job_type head_job,
   output logic                 pop,
   // Result transaction
   output logic                 out_valid,
   input  logic                 out_ready,
   output logic [6:0]           text_char,
   output logic                 is_checksum,
   output logic                 last_char
);
   import rae_pkg::*;

   logic [2:0]  pos_ff, pos_in;
   logic        valid_ff, valid_in;
   logic [6:0]  char_ff, char_in;
   logic        chk_ff, chk_in;
   logic        last_ff, last_in;
   logic        load, fire;
   logic        has_grp, crc_phase, job_last;
   logic [1:0]  k;
   logic [23:0] word;
   logic [5:0]  sextet;

   assign load      = !valid_ff || out_ready;
   assign fire      = load && !queue_empty;
   assign has_grp   = (head_job.grp_bytes != 2'd0);
   assign crc_phase = !has_grp || pos_ff[2];
   assign k         = pos_ff[1:0];
   assign word      = crc_phase ? head_job.crc : head_job.grp;
   assign job_last  = (k == 2'd3) && (crc_phase || !head_job.has_crc);
   assign pop       = fire && job_last;

   // Pick the six bits of the current character, most significant first.
   always_comb begin
      unique case (k)
         2'd0:    sextet = word[23:18];
         2'd1:    sextet = word[17:12];
         2'd2:    sextet = word[11:6];
         default: sextet = word[5:0];
      endcase
   end

   // Next output character and position within the job.
   always_comb begin
      valid_in = valid_ff;
      char_in  = char_ff;
      chk_in   = chk_ff;
      last_in  = last_ff;
      pos_in   = pos_ff;
      if (load) begin
         valid_in = !queue_empty;
      end
      if (fire) begin
         if (!crc_phase && (k > head_job.grp_bytes)) begin
            char_in = PadChar;
         end else begin
            char_in = b64_char(sextet);
         end
         chk_in  = crc_phase;
         last_in = crc_phase && (k == 2'd3);
         pos_in  = job_last ? 3'd0 : pos_ff + 3'd1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
         pos_ff   <= '0;
      end else begin
         valid_ff <= valid_in;
         pos_ff   <= pos_in;
      end
   end

   // Output payload needs no reset.
   always_ff @(posedge clock) begin
      char_ff <= char_in;
      chk_ff  <= chk_in;
      last_ff <= last_in;
   end

   assign out_valid   = valid_ff;
   assign text_char   = char_ff;
   assign is_checksum = chk_ff;
   assign last_char   = last_ff;

endmodule

### sv/radix64_armor_encoder_core.sv
// Radix-64 armor encoder: base64 text of a message followed by its CRC-24.
// An item's first character comes out through the job queue, then the output register.
// Throughput: one input item per cycle while the job queue has room; one output character
// per cycle while rsp_tready is high, set by the single-character output register.
// A message of n bytes yields 4*ceil(n/3)+4 characters.
// Reset (synchronous, active high) empties the queue and output and restores CRC defaults.
module radix64_armor_encoder_core #(
   parameter int FifoDepth = rae_pkg::FifoDepth
) (
   input  logic                              clock,
   input  logic                              reset,
   // Message input
   input  logic                              req_tvalid,
   output logic                              req_tready,
   input  logic [7:0]                        req_tdata,   // [7:0] data_byte
   input  logic                              req_tuser,   // [0] byte_present
   input  logic                              req_tlast,   // end_of_message
   // Character output
   output logic                              rsp_tvalid,
   input  logic                              rsp_tready,
   output logic [7:0]                        rsp_tdata,   // [6:0] text_char, [7] zero
   output logic                              rsp_tuser,   // [0] is_checksum
   output logic                              rsp_tlast,   // last_char
   // Configuration write
   input  logic                              csr_valid,
   output logic                              csr_ready,
   input  logic [rae_pkg::CsrIndexWidth-1:0] csr_index,
   input  logic [rae_pkg::CrcWidth-1:0]      csr_data
);
   import rae_pkg::*;

   rae_job_type push_job, head_job;
   logic        push, pop, queue_full, queue_empty;
   logic [6:0]  text_char;

   assign csr_ready = 1'b1;

   rae_front u_front (
      .clock          (clock),
      .reset          (reset),
      .in_valid       (req_tvalid),
      .in_ready       (req_tready),
      .data_byte      (req_tdata),
      .byte_present   (req_tuser),
      .end_of_message (req_tlast),
      .csr_valid      (csr_valid),
      .csr_index      (csr_index),
      .csr_data       (csr_data),
      .queue_full     (queue_full),
      .push           (push),
      .push_job       (push_job)
   );

   rae_fifo #(
      .Depth (FifoDepth)
   ) u_fifo (
      .clock    (clock),
      .reset    (reset),
      .push     (push),
      .push_job (push_job),
      .full     (queue_full),
      .pop      (pop),
      .empty    (queue_empty),
      .head_job (head_job)
   );

   rae_back u_back (
      .clock       (clock),
      .reset       (reset),
      .queue_empty (queue_empty),
      .head_job    (head_job),
      .pop         (pop),
      .out_valid   (rsp_tvalid),
      .out_ready   (rsp_tready),
      .text_char   (text_char),
      .is_checksum (rsp_tuser),
      .last_char   (rsp_tlast)
   );

   assign rsp_tdata = {1'b0, text_char};

endmodule

### sv/rae_checker.sv
// Port-level assertions for the radix-64 armor encoder, bound to the top level.
// Depends on rae_pkg for widths only.
module rae_checker (
   input logic                              clock,
   input logic                              reset,
   input logic                              rsp_tvalid,
   input logic                              rsp_tready,
   input logic [7:0]                        rsp_tdata,
   input logic                              rsp_tuser,
   input logic                              rsp_tlast
);
   import rae_pkg::*;

   // The final character of a message always belongs to the checksum text.
   a_last_is_checksum: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && rsp_tlast |-> rsp_tuser)
      else $error("last character outside checksum text");

   // Characters are seven-bit ASCII.
   a_ascii: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid |-> (rsp_tdata[7] == 1'b0))
      else $error("output character above 7 bits");

   // Nothing is offered in the cycle after reset.
   a_reset_idle: assert property (@(posedge clock)
      reset |=> !rsp_tvalid)
      else $error("output valid right after reset");

   // A stalled transaction holds its payload.
   a_stall_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && !rsp_tready |=> rsp_tvalid && $stable(rsp_tdata)
         && $stable(rsp_tuser) && $stable(rsp_tlast))
      else $error("stalled output changed");

endmodule

bind radix64_armor_encoder_core rae_checker u_rae_checker (
   .clock      (clock),
   .reset      (reset),
   .rsp_tvalid (rsp_tvalid),
   .rsp_tready (rsp_tready),
   .rsp_tdata  (rsp_tdata),
   .rsp_tuser  (rsp_tuser),
   .rsp_tlast  (rsp_tlast)
);
